### hw/rtl/fppt_pkg.sv
// Shared types, widths, constants and table functions for the focus phase pipeline.
package fppt_pkg;

  localparam int CoordInW = 12;
  localparam int HalfW    = 11;
  localparam int BoardW   = 2;
  localparam int ChanW    = 6;

  localparam int PhasePeriod = 512;
  localparam int PhaseW      = $clog2(PhasePeriod);
  localparam logic [PhaseW-1:0] HalfPeriod = PhaseW'(PhasePeriod / 2);

  localparam int PosW    = 11;
  localparam int DiffW   = 13;
  localparam int SqW     = 24;
  localparam int SumW    = 25;
  localparam int FracW   = 4;
  localparam int RadW    = SumW + 2 * FracW;
  localparam int RootW   = (RadW + 1) / 2;
  localparam int RadPadW = 2 * RootW;
  localparam int RemW    = RootW + 1;

  localparam int KsW                = 15;
  localparam logic [KsW-1:0] KsQ12Mag = KsW'(24457);
  localparam int ProdW              = RootW + KsW;
  localparam int MagShift           = 16;

  localparam int NumCols  = 5;
  localparam int ColIdxW  = 3;
  localparam int RowIdxW  = 4;

  localparam logic [HalfW-1:0] HalfHeightRst = HalfW'(675);

  typedef logic signed [DiffW-1:0] diff_t;

  typedef struct packed {
    diff_t dx;
    diff_t dy;
    diff_t dz;
  } diff_vec_t;

  // travels with every item down the pipe
  typedef struct packed {
    logic valid;
    logic bottom;
  } tag_t;

  typedef struct packed {
    logic [ColIdxW-1:0] col;
    logic [RowIdxW-1:0] row;
  } chan_pos_t;

  function automatic logic signed [PosW-1:0] col_x(input logic [ColIdxW-1:0] col);
    logic signed [PosW-1:0] x;
    unique case (col)
      3'd0:    x = PosW'(450);
      3'd1:    x = PosW'(350);
      3'd2:    x = PosW'(250);
      3'd3:    x = PosW'(150);
      default: x = PosW'(50);
    endcase
    return x;
  endfunction

  function automatic logic signed [PosW-1:0] row_z(input logic [RowIdxW-1:0] row);
    logic signed [PosW-1:0] z;
    unique case (row)
      4'd0:    z = -PosW'(450);
      4'd1:    z = -PosW'(350);
      4'd2:    z = -PosW'(250);
      4'd3:    z = -PosW'(150);
      4'd4:    z = -PosW'(50);
      4'd5:    z = PosW'(50);
      4'd6:    z = PosW'(150);
      4'd7:    z = PosW'(250);
      4'd8:    z = PosW'(350);
      default: z = PosW'(450);
    endcase
    return z;
  endfunction

  // column is channel/10 saturated at the last column, row is channel mod 10
  function automatic chan_pos_t chan_split(input logic [ChanW-1:0] ch);
    chan_pos_t        pos;
    logic [2:0]       q;
    logic [ChanW-1:0] tens;
    logic [ChanW-1:0] rem;
    priority if (ch >= ChanW'(60)) q = 3'd6;
    else if (ch >= ChanW'(50))     q = 3'd5;
    else if (ch >= ChanW'(40))     q = 3'd4;
    else if (ch >= ChanW'(30))     q = 3'd3;
    else if (ch >= ChanW'(20))     q = 3'd2;
    else if (ch >= ChanW'(10))     q = 3'd1;
    else                           q = 3'd0;
    tens    = ChanW'({q, 3'b000}) + ChanW'({q, 1'b0});
    rem     = ch - tens;
    pos.row = rem[RowIdxW-1:0];
    pos.col = (q > ColIdxW'(NumCols - 1)) ? ColIdxW'(NumCols - 1) : q;
    return pos;
  endfunction

endpackage

### hw/rtl/focus_phase_per_transducer.sv
// Throughput: one transducer per cycle unless in_stall_o holds the input;
// 3 geometry stages, 17 root stages (one root bit each), one multiply stage
// and the output register.
// A skid stage behind the output register makes in_stall_o a registered signal.
// Reset clears all valid bits and loads half_height with 675.
module focus_phase_per_transducer import fppt_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [HalfW-1:0]           cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [CoordInW-1:0] target_x_i,
  input  logic signed [CoordInW-1:0] target_y_i,
  input  logic signed [CoordInW-1:0] target_z_i,
  input  logic [BoardW-1:0]          board_i,
  input  logic [ChanW-1:0]           channel_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [PhaseW-1:0]          phase_o
);

  logic [HalfW-1:0] half_height_q;
  logic             advance;
  tag_t             geom_tag;
  logic [SumW-1:0]  geom_sum;
  tag_t             root_tag;
  logic [RootW-1:0] root;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_height_q <= HalfHeightRst;
    end else if (cfg_we_i) begin
      half_height_q <= cfg_wdata_i;
    end
  end

  assign in_stall_o = !advance;

  fppt_geom u_geom (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .advance_i     (advance),
    .valid_i       (in_valid_i),
    .target_x_i    (target_x_i),
    .target_y_i    (target_y_i),
    .target_z_i    (target_z_i),
    .board_i       (board_i),
    .channel_i     (channel_i),
    .half_height_i (half_height_q),
    .tag_o         (geom_tag),
    .sum_o         (geom_sum)
  );

  fppt_isqrt u_isqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .tag_i     (geom_tag),
    .sum_i     (geom_sum),
    .tag_o     (root_tag),
    .root_o    (root)
  );

  fppt_phase u_phase (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tag_i       (root_tag),
    .root_i      (root),
    .out_stall_i (out_stall_i),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .phase_o     (phase_o)
  );

endmodule

### hw/rtl/fppt_geom.sv
// Geometry stages: coordinate differences, squares and squared distance.
module fppt_geom import fppt_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       advance_i,
  input  logic                       valid_i,
  input  logic signed [CoordInW-1:0] target_x_i,
  input  logic signed [CoordInW-1:0] target_y_i,
  input  logic signed [CoordInW-1:0] target_z_i,
  input  logic [BoardW-1:0]          board_i,
  input  logic [ChanW-1:0]           channel_i,
  input  logic [HalfW-1:0]           half_height_i,
  output tag_t                       tag_o,
  output logic [SumW-1:0]            sum_o
);

  chan_pos_t              pos;
  logic signed [PosW-1:0] cx;
  logic signed [PosW-1:0] px;
  logic signed [PosW-1:0] pz;
  diff_t                  hh;
  diff_t                  py;
  diff_t                  tx;
  diff_t                  ty;
  diff_t                  tz;
  diff_vec_t              d1_d, d1_q;
  tag_t                   tag1_d, tag1_q, tag2_q, tag3_q;

  logic signed [2*DiffW-1:0] px2, py2, pz2;
  logic [SqW-1:0]            sqx_d, sqy_d, sqz_d;
  logic [SqW-1:0]            sqx_q, sqy_q, sqz_q;
  logic [SumW-1:0]           sum_d, sum_q;

  // stage 1: transducer position and differences
  always_comb begin
    pos  = chan_split(channel_i);
    cx   = col_x(pos.col);
    px   = board_i[0] ? -cx : cx;
    pz   = row_z(pos.row);
    hh   = {{(DiffW-HalfW){1'b0}}, half_height_i};
    py   = board_i[1] ? -hh : hh;
    tx   = {{(DiffW-CoordInW){target_x_i[CoordInW-1]}}, target_x_i};
    ty   = {{(DiffW-CoordInW){target_y_i[CoordInW-1]}}, target_y_i};
    tz   = {{(DiffW-CoordInW){target_z_i[CoordInW-1]}}, target_z_i};
    d1_d.dx = tx - {{(DiffW-PosW){px[PosW-1]}}, px};
    d1_d.dy = ty - py;
    d1_d.dz = tz - {{(DiffW-PosW){pz[PosW-1]}}, pz};
    tag1_d.valid  = valid_i;
    tag1_d.bottom = board_i[1];
  end

  // stage 2: squares, each below 2^SqW
  always_comb begin
    px2   = d1_q.dx * d1_q.dx;
    py2   = d1_q.dy * d1_q.dy;
    pz2   = d1_q.dz * d1_q.dz;
    sqx_d = px2[SqW-1:0];
    sqy_d = py2[SqW-1:0];
    sqz_d = pz2[SqW-1:0];
  end

  // stage 3: sum
  assign sum_d = SumW'(sqx_q) + SumW'(sqy_q) + SumW'(sqz_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      tag3_q <= '0;
    end else if (advance_i) begin
      tag1_q <= tag1_d;
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      d1_q  <= d1_d;
      sqx_q <= sqx_d;
      sqy_q <= sqy_d;
      sqz_q <= sqz_d;
      sum_q <= sum_d;
    end
  end

  assign tag_o = tag3_q;
  assign sum_o = sum_q;

endmodule

### hw/rtl/fppt_isqrt.sv
// Pipelined restoring square root, one result bit per stage, 4 fractional bits.
module fppt_isqrt import fppt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  tag_t             tag_i,
  input  logic [SumW-1:0]  sum_i,
  output tag_t             tag_o,
  output logic [RootW-1:0] root_o
);

  logic [RadPadW-1:0] rad_in  [RootW];
  logic [RemW-1:0]    rem_in  [RootW];
  logic [RootW-1:0]   root_in [RootW];
  tag_t               tag_in  [RootW];

  logic [RadPadW-1:0] rad_d  [RootW];
  logic [RemW-1:0]    rem_d  [RootW];
  logic [RootW-1:0]   root_d [RootW];

  logic [RadPadW-1:0] rad_q  [RootW-1];
  logic [RemW-1:0]    rem_q  [RootW-1];
  logic [RootW-1:0]   root_q [RootW];
  tag_t               tag_q  [RootW];

  for (genvar k = 0; k < RootW; k++) begin : g_stage
    logic [RemW+1:0] cur;
    logic [RemW+1:0] trial;
    logic            ge;

    if (k == 0) begin : g_head
      // radicand is sum * 256
      assign rad_in[k]  = RadPadW'({sum_i, {(2*FracW){1'b0}}});
      assign rem_in[k]  = '0;
      assign root_in[k] = '0;
      assign tag_in[k]  = tag_i;
    end else begin : g_body
      assign rad_in[k]  = rad_q[k-1];
      assign rem_in[k]  = rem_q[k-1];
      assign root_in[k] = root_q[k-1];
      assign tag_in[k]  = tag_q[k-1];
    end

    always_comb begin
      cur       = {rem_in[k], rad_in[k][RadPadW-1 -: 2]};
      trial     = (RemW+2)'({root_in[k], 2'b01});
      ge        = (cur >= trial);
      rem_d[k]  = ge ? RemW'(cur - trial) : RemW'(cur);
      root_d[k] = {root_in[k][RootW-2:0], ge};
      rad_d[k]  = {rad_in[k][RadPadW-3:0], 2'b00};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[k] <= '0;
      end else if (advance_i) begin
        tag_q[k] <= tag_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (advance_i) begin
        root_q[k] <= root_d[k];
      end
    end

    if (k < RootW - 1) begin : g_fwd
      always_ff @(posedge clk_i) begin
        if (advance_i) begin
          rad_q[k] <= rad_d[k];
          rem_q[k] <= rem_d[k];
        end
      end
    end
  end

  assign tag_o  = tag_q[RootW-1];
  assign root_o = root_q[RootW-1];

endmodule

### hw/rtl/fppt_phase.sv
// Distance to phase scaling, wrap into the period, output register and skid stage.
module fppt_phase import fppt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tag_t              tag_i,
  input  logic [RootW-1:0]  root_i,
  input  logic              out_stall_i,
  output logic              advance_o,
  output logic              out_valid_o,
  output logic [PhaseW-1:0] phase_o
);

  tag_t              mtag_q;
  logic [ProdW-1:0]  prod_q;
  logic [PhaseW-1:0] phase_d;
  logic              push;

  logic              out_v_d, out_v_q;
  logic [PhaseW-1:0] out_ph_d, out_ph_q;
  logic              skid_v_d, skid_v_q;
  logic [PhaseW-1:0] skid_ph_d, skid_ph_q;

  assign advance_o = !skid_v_q;
  assign push      = advance_o && mtag_q.valid;

  // magnitude is floor(D*K/2^16); phase is its negation mod the period, plus half a period for the bottom board
  always_comb begin
    phase_d = PhaseW'(0) - prod_q[MagShift +: PhaseW];
    if (mtag_q.bottom) begin
      phase_d = phase_d + HalfPeriod;
    end
  end

  always_comb begin
    out_v_d   = out_v_q;
    out_ph_d  = out_ph_q;
    skid_v_d  = skid_v_q;
    skid_ph_d = skid_ph_q;
    if (!out_v_q || !out_stall_i) begin
      if (skid_v_q) begin
        out_v_d  = 1'b1;
        out_ph_d = skid_ph_q;
        skid_v_d = 1'b0;
      end else begin
        out_v_d  = push;
        out_ph_d = phase_d;
      end
    end else if (push) begin
      skid_v_d  = 1'b1;
      skid_ph_d = phase_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mtag_q   <= '0;
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (advance_o) begin
        mtag_q <= tag_i;
      end
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      prod_q <= ProdW'(root_i) * ProdW'(KsQ12Mag);
    end
    out_ph_q  <= out_ph_d;
    skid_ph_q <= skid_ph_d;
  end

  assign out_valid_o = out_v_q;
  assign phase_o     = out_ph_q;

endmodule

### hw/rtl/fppt_checker.sv
// Port-level assertions for the focus phase block, bound to the top level.
module fppt_checker import fppt_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [PhaseW-1:0] phase_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(phase_o))
    else $error("stalled phase changed");

  // input back-pressure only appears behind a stalled, full output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without output back-pressure");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled while output register empty");

endmodule

bind focus_phase_per_transducer fppt_checker u_chk (.*);
